### design/disk_block_bitmap_allocator_unit_assert.svh
// assertion macros for the disk block bitmap allocator
// simulation builds get concurrent checks, synthesis builds get empty bodies
// no dependencies
`ifndef DISK_BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define DISK_BLOCK_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle as the trigger
`define DBBA_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dbba assertion failed");

// condition must hold in the cycle after the trigger
`define DBBA_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dbba assertion failed");

`else

`define DBBA_ASSERT_SAME(label, clk, rst, pre, post)
`define DBBA_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

### design/dbba_pkg.sv
// shared types and constants for the disk block bitmap allocator
// used by dbba_find_free and disk_block_bitmap_allocator_unit
`timescale 1ns / 1ps

package dbba_pkg;

  // map size, a power of two from 32 to 256
  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);

  // item and register field widths
  localparam int OP_W    = 2;
  localparam int BLK_W   = 8;
  localparam int CNT_W   = 9;
  localparam int TOTAL_W = 9;
  localparam int DIR_W   = 5;

  // stream and config port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(243);
  localparam logic [DIR_W-1:0]   DIR_RESET   = DIR_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_ALLOC = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_BLOCKS     = 1'b0,
    CFG_DIRECTORY_BLOCKS = 1'b1
  } cfg_reg_t;

  // lowest clear bit of the map
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_t;

endpackage

### design/disk_block_bitmap_allocator_unit.sv
// disk block bitmap allocator: clear / mark / allocate on a one-bit-per-block map
// depends on dbba_pkg, dbba_find_free and disk_block_bitmap_allocator_unit_assert.svh
//
//  channel   direction  signals                     beat contents (low bit first)
//  s_*       in         tvalid tready tdata tuser   tdata: block[7:0]; tuser: operation[1:0]
//  m_*       out        tvalid tready tdata tuser   tdata: allocated_block[7:0],
//                                                   used_count[16:8], zero pad; tuser: full_res
//  cfg_*     in         we index data               index 0 total_blocks, 1 directory_blocks
//
//  every operation is computed in the single compute stage between the input
//  register and the result register; the 256-leaf free-bit tree sets that path.
//  one beat in per cycle unless m stalls; a beat passes the input, then the result register.
//  rst (synchronous) clears the map, the used count and both pipeline valids and
//  loads total_blocks 243, directory_blocks 2; no clearing pass is needed.
//  an m-side stall holds the result register, and the input register then holds too.
`timescale 1ns / 1ps
`include "disk_block_bitmap_allocator_unit_assert.svh"

module disk_block_bitmap_allocator_unit (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dbba_pkg::IN_TDATA_W-1:0]  s_tdata,   // block[7:0]
  input  logic [dbba_pkg::OP_W-1:0]        s_tuser,   // operation[1:0]
  // master side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dbba_pkg::OUT_TDATA_W-1:0] m_tdata,   // allocated_block[7:0], used_count[16:8]
  output logic                             m_tuser,   // full_res
  // config write port
  input  logic                             cfg_we,
  input  logic [dbba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dbba_pkg::*;

  localparam logic [BLK_W:0] BLK_LIMIT = (BLK_W + 1)'(MAX_BLOCKS);

  // config registers
  logic [TOTAL_W-1:0] total_blocks;
  logic [DIR_W-1:0]   directory_blocks;

  // map state
  logic [MAX_BLOCKS-1:0] used_map, used_map_next;
  logic [CNT_W-1:0]      used_total, used_total_next;

  // input register
  logic             in_valid;
  op_t              in_op;
  logic [BLK_W-1:0] in_blk;

  // result register
  logic             out_valid;
  logic [BLK_W-1:0] out_block, out_block_next;
  logic             out_full, out_full_next;
  logic [CNT_W-1:0] out_count;

  logic  advance;
  logic  fire;
  free_t free;
  logic  mark_ok;
  logic  alloc_ok;

  // result register is empty or drains this cycle
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  dbba_find_free u_find_free (
    .used_map (used_map),
    .free     (free)
  );

  // mark ignores block zero (end of a pointer list), blocks past the map and busy blocks
  assign mark_ok  = (in_blk != '0) && ({1'b0, in_blk} < BLK_LIMIT)
                    && !used_map[in_blk[IDX_W-1:0]];
  // allocate only below total_blocks
  assign alloc_ok = free.found && (TOTAL_W'(free.idx) < total_blocks);

  always_comb begin
    used_map_next   = used_map;
    used_total_next = used_total;
    out_block_next  = '0;
    out_full_next   = 1'b0;
    case (in_op)
      OP_CLEAR: begin
        // directory never exceeds 31 blocks, always inside the map
        used_map_next   = ~({MAX_BLOCKS{1'b1}} << directory_blocks);
        used_total_next = CNT_W'(directory_blocks);
      end
      OP_MARK: begin
        if (mark_ok) begin
          used_map_next[in_blk[IDX_W-1:0]] = 1'b1;
          used_total_next                  = used_total + 1'b1;
        end
      end
      OP_ALLOC: begin
        if (alloc_ok) begin
          used_map_next[free.idx] = 1'b1;
          used_total_next         = used_total + 1'b1;
          out_block_next          = BLK_W'(free.idx);
        end else begin
          out_full_next = 1'b1;
        end
      end
      default: begin
        // unused code: no change, plain status beat
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      used_map         <= '0;
      used_total       <= '0;
      total_blocks     <= TOTAL_RESET;
      directory_blocks <= DIR_RESET;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (s_tvalid && s_tready) begin
        in_op  <= op_t'(s_tuser);
        in_blk <= s_tdata[BLK_W-1:0];
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        out_block  <= out_block_next;
        out_full   <= out_full_next;
        out_count  <= used_total_next;
        used_map   <= used_map_next;
        used_total <= used_total_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL_BLOCKS:     total_blocks     <= cfg_data[TOTAL_W-1:0];
          CFG_DIRECTORY_BLOCKS: directory_blocks <= cfg_data[DIR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - BLK_W - CNT_W)'(0), out_count, out_block};
  assign m_tuser  = out_full;

  // running count matches the map
  `DBBA_ASSERT_SAME(a_count_matches_map, clk, rst, 1'b1,
                    $countones(used_map) == int'(used_total))
  // a full result never names a block
  `DBBA_ASSERT_SAME(a_full_has_no_block, clk, rst, out_valid && out_full,
                    out_block == '0)
  // clear leaves the used count equal to directory_blocks
  `DBBA_ASSERT_NEXT(a_clear_count, clk, rst, fire && (in_op == OP_CLEAR),
                    used_total == CNT_W'(directory_blocks))

endmodule

### design/dbba_find_free.sv
// lowest-clear-bit search over the used map, binary tree of pair selects
// depends on dbba_pkg
`timescale 1ns / 1ps

module dbba_find_free (
  input  logic [dbba_pkg::MAX_BLOCKS-1:0] used_map,
  output dbba_pkg::free_t                 free
);
  import dbba_pkg::*;

  localparam int LEVELS = IDX_W;

  logic             lvl_found [0:LEVELS][0:MAX_BLOCKS-1];
  logic [IDX_W-1:0] lvl_idx   [0:LEVELS][0:MAX_BLOCKS-1];

  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int n = 0; n < MAX_BLOCKS; n++) begin
        lvl_found[l][n] = 1'b0;
        lvl_idx[l][n]   = '0;
      end
    end
    // leaves: one per block
    for (int n = 0; n < MAX_BLOCKS; n++) begin
      lvl_found[0][n] = ~used_map[n];
      lvl_idx[0][n]   = IDX_W'(n);
    end
    // each node prefers its lower half
    for (int l = 0; l < LEVELS; l++) begin
      for (int n = 0; n < MAX_BLOCKS / 2; n++) begin
        if (n < (MAX_BLOCKS >> (l + 1))) begin
          lvl_found[l+1][n] = lvl_found[l][2*n] | lvl_found[l][2*n+1];
          lvl_idx[l+1][n]   = lvl_found[l][2*n] ? lvl_idx[l][2*n] : lvl_idx[l][2*n+1];
        end
      end
    end
  end

  assign free.found = lvl_found[LEVELS][0];
  assign free.idx   = lvl_idx[LEVELS][0];

endmodule

### tb/disk_block_bitmap_allocator_unit_test.sv
`timescale 1ns / 1ps
// self-checking bench for disk_block_bitmap_allocator_unit: clear, mark and allocate beats
// checked against a bitmap predictor kept in a small scoreboard class
// depends on dbba_pkg and the allocator rtl

module disk_block_bitmap_allocator_unit_test;
  import dbba_pkg::*;

  // operation code with no meaning, the block must pass it through untouched
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 500;   // cycles with no beat and no write before giving up
  localparam int N_MIXED_PHASES = 10;

  // one result beat, unpacked
  typedef struct packed {
    logic [BLK_W-1:0] block;
    logic             full;
    logic [CNT_W-1:0] count;
  } alloc_result_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_EVERY4,
    SINK_BURSTY
  } sink_mode_t;

  // bitmap predictor plus the queue of results still owed by the block
  class alloc_scoreboard;
    logic [MAX_BLOCKS-1:0] used_map;
    logic [CNT_W-1:0]      used_total;
    logic [TOTAL_W-1:0]    total_blocks;
    logic [DIR_W-1:0]      dir_blocks;
    alloc_result_t         expected_q[$];
    int                    errors;

    function new();
      used_map     = '0;
      used_total   = '0;
      total_blocks = TOTAL_RESET;
      dir_blocks   = DIR_RESET;
      errors       = 0;
    endfunction

    // advance the map for one accepted input beat and queue its result
    function void note_item(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
      alloc_result_t r;
      int k;
      r = '0;
      case (op)
        OP_CLEAR: begin
          used_map   = '0;
          used_total = '0;
          for (k = 0; k < int'(dir_blocks) && k < MAX_BLOCKS; k++) begin
            used_map[k] = 1'b1;
            used_total++;
          end
        end
        OP_MARK: begin
          // block zero ends a pointer list, a busy block stays counted once
          if (blk != '0 && int'(blk) < MAX_BLOCKS && !used_map[blk]) begin
            used_map[blk] = 1'b1;
            used_total++;
          end
        end
        OP_ALLOC: begin
          k = 0;
          while (k < MAX_BLOCKS && used_map[k]) k++;
          if (k >= MAX_BLOCKS || k >= int'(total_blocks)) begin
            r.full = 1'b1;
          end else begin
            used_map[k] = 1'b1;
            used_total++;
            r.block = BLK_W'(k);
          end
        end
        default: begin
        end
      endcase
      r.count = used_total;
      expected_q.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: block %0d full %0d count %0d",
                 $time, got.block, got.full, got.count);
      end else begin
        exp = expected_q.pop_front();
        if (exp !== got) begin
          errors++;
          $display("%0t: mismatch, expected blk %0d full %0d cnt %0d, got blk %0d full %0d cnt %0d",
                   $time, exp.block, exp.full, exp.count, got.block, got.full, got.count);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // block[7:0]
  logic [OP_W-1:0]        s_tuser = '0;   // operation[1:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // allocated_block[7:0], used_count[16:8], zero pad
  logic                   m_tuser;        // full_res
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  alloc_scoreboard sb;

  // sender burst bookkeeping
  int burst_left = 0;

  // receiver pattern state
  sink_mode_t sink_mode = SINK_OPEN;
  int mode_left = 0;
  int stall_left = 0;
  int sink_tick = 0;

  int idle_cycles = 0;

  disk_block_bitmap_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitor: everything sampled at the edge, before this step's updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_item(s_tuser, s_tdata[BLK_W-1:0]);
      if (m_tvalid && m_tready)
        sb.check_result(alloc_result_t'{m_tdata[BLK_W-1:0], m_tuser,
                                        m_tdata[BLK_W+CNT_W-1:BLK_W]});
    end
  end

  // receiver: switches between open, coin-flip, periodic (SINK_EVERY4) and bursty stalls
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (mode_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   m_tready <= 1'b1;
      SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
      SINK_EVERY4: m_tready <= (sink_tick % 4) != 0;
      default: begin
        if (stall_left > 0) begin
          m_tready   <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(2, 8);
        end
      end
    endcase
  end

  // watchdog: no beat on either side and no register write for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // present one beat and hold it until taken; valid stays high inside a burst
  task automatic put_item(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_TDATA_W'(blk);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // next burst; a third of them follow with no gap at all
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drain the block, then load both registers back to back
  task automatic write_regs(input logic [TOTAL_W-1:0] total, input logic [DIR_W-1:0] dirs);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOTAL_BLOCKS;
    cfg_data  <= CFG_DATA_W'(total);
    @(posedge clk);
    sb.total_blocks = total;
    cfg_index <= CFG_DIRECTORY_BLOCKS;
    cfg_data  <= CFG_DATA_W'(dirs);
    @(posedge clk);
    sb.dir_blocks = dirs;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mark targets: the end-of-list zero, the busy low region, the disk edge, anywhere
  function automatic logic [BLK_W-1:0] pick_block(input logic [TOTAL_W-1:0] total);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 4) return BLK_W'($urandom_range(1, 40));
    if (r < 6) begin
      v = int'(total) - 2 + $urandom_range(0, 4);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return BLK_W'(v);
    end
    return BLK_W'($urandom_range(0, 255));
  endfunction

  // one setting: program it, start from a clear, then a random mix of operations
  task automatic run_phase(input logic [TOTAL_W-1:0] total, input logic [DIR_W-1:0] dirs,
                           input int n_items, input int alloc_pct, input bit clear_ok);
    int i;
    int r;
    write_regs(total, dirs);
    put_item(OP_CLEAR, BLK_W'($urandom_range(0, 255)));
    for (i = 1; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        put_item(OP_ALLOC, BLK_W'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0 && clear_ok)
          put_item(OP_CLEAR, BLK_W'($urandom_range(0, 255)));
        else if (r == 1)
          put_item(OP_UNUSED, BLK_W'($urandom_range(0, 255)));
        else
          put_item(OP_MARK, pick_block(total));
      end
    end
  endtask

  initial begin
    int p;
    logic [TOTAL_W-1:0] total;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 243 blocks, 2 directory blocks, empty map
    put_item(OP_UNUSED, 8'hAA);   // no change, count stays zero
    put_item(OP_ALLOC, 8'hFF);    // empty map hands out block 0
    put_item(OP_MARK, 8'h00);     // end-of-list marker, ignored
    put_item(OP_MARK, 8'hFF);
    put_item(OP_MARK, 8'hFF);     // already busy, count unchanged
    put_item(OP_MARK, 8'h01);
    put_item(OP_ALLOC, 8'h00);    // skips 0 and 1
    put_item(OP_CLEAR, 8'h55);    // back to just the directory
    put_item(OP_MARK, 8'd250);    // past total_blocks, still counted
    put_item(OP_ALLOC, 8'h00);

    // directory bigger than the disk: full straight after a clear
    write_regs(9'd4, 5'd31);
    put_item(OP_CLEAR, 8'h00);
    put_item(OP_ALLOC, 8'h00);
    put_item(OP_MARK, 8'd2);

    // zero-size disk: allocate is full even on an empty map
    write_regs(9'd0, 5'd0);
    put_item(OP_CLEAR, 8'h00);
    put_item(OP_ALLOC, 8'h00);

    // single-block disk
    write_regs(9'd1, 5'd0);
    put_item(OP_CLEAR, 8'hFF);
    put_item(OP_ALLOC, 8'h00);
    put_item(OP_ALLOC, 8'h00);
    put_item(OP_MARK, 8'h01);
    put_item(OP_ALLOC, 8'h00);

    // total above the map: fill all 256 bits, then the search itself runs out
    run_phase(9'd511, 5'd31, 320, 95, 1'b0);
    // exactly the map size with no directory, count reaches 256
    run_phase(9'd256, 5'd0, 300, 95, 1'b0);
    // mixed settings, small disks half the time so full comes up often
    for (p = 0; p < N_MIXED_PHASES; p++) begin
      if ($urandom_range(0, 1) == 0)
        total = TOTAL_W'($urandom_range(1, 48));
      else
        total = TOTAL_W'($urandom_range(0, 511));
      run_phase(total, DIR_W'($urandom_range(0, 31)), 120, 60, 1'b1);
    end

    // drain and allow the input and result registers to settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
